### sv/sitoda_pkg.sv
// ----------------------------------------------------------------------------
// sitoda_pkg
// Shared types, constants and the control store of the signed integer to
// decimal text converter.
// ----------------------------------------------------------------------------
package sitoda_pkg;

   // default integer width of an input item
   localparam int DEFAULT_WIDTH = 32;

   // ascii codes used on the result channel
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_NINE  = 8'h39;
   localparam logic [7:0] ASCII_MINUS = 8'h2d;

   // width of the step counter
   localparam int PC_W = 3;

   // step numbers of the program
   localparam logic [PC_W-1:0] STEP_LOAD   = 3'd0;
   localparam logic [PC_W-1:0] STEP_DABBLE = 3'd1;
   localparam logic [PC_W-1:0] STEP_TEST   = 3'd2;
   localparam logic [PC_W-1:0] STEP_SIGN   = 3'd3;
   localparam logic [PC_W-1:0] STEP_SKIP   = 3'd4;
   localparam logic [PC_W-1:0] STEP_DIGIT  = 3'd5;
   localparam logic [PC_W-1:0] STEP_DONE   = 3'd6;

   // datapath action of one step
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_DABBLE,
      ACT_SIGN,
      ACT_SKIP,
      ACT_DIGIT
   } act_type;

   // jump condition of one step
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_INPUT,
      COND_BITS_LEFT,
      COND_NOT_NEG,
      COND_LEAD_ZERO,
      COND_DIGITS_LEFT
   } cond_type;

   // one control word
   typedef struct packed {
      act_type         act;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   // control store: a taken jump goes to target, otherwise to the next step
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type word;
      unique case (pc)
         STEP_LOAD:   word = '{act: ACT_LOAD,   cond: COND_NO_INPUT,    target: STEP_LOAD};
         STEP_DABBLE: word = '{act: ACT_DABBLE, cond: COND_BITS_LEFT,   target: STEP_DABBLE};
         STEP_TEST:   word = '{act: ACT_NONE,   cond: COND_NOT_NEG,     target: STEP_SKIP};
         STEP_SIGN:   word = '{act: ACT_SIGN,   cond: COND_NEVER,       target: STEP_LOAD};
         STEP_SKIP:   word = '{act: ACT_SKIP,   cond: COND_LEAD_ZERO,   target: STEP_SKIP};
         STEP_DIGIT:  word = '{act: ACT_DIGIT,  cond: COND_DIGITS_LEFT, target: STEP_DIGIT};
         STEP_DONE:   word = '{act: ACT_NONE,   cond: COND_ALWAYS,      target: STEP_LOAD};
         default:     word = '{act: ACT_NONE,   cond: COND_ALWAYS,      target: STEP_LOAD};
      endcase
      return word;
   endfunction

endpackage

### sv/signed_int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed two's complement integer into its decimal ascii text.
// ----------------------------------------------------------------------------
// usage
// - req channel: one item is a WIDTH-bit signed integer in req_tdata
// - rsp channel: one ascii character per item, most significant first; a
//   leading '-' for negative values, a single '0' for zero; rsp_tlast marks
//   the final character of each number
// - a small program in a control store steps a plain datapath: load, WIDTH
//   shift-and-add-3 steps of a bcd register, an optional sign, a skip over
//   leading zero digits (one digit a cycle), then one digit out per cycle
//   while the output register is free; the bcd register holds NDIG digits
//   (10 at WIDTH = 32), and the shift loop over the input bits takes most
//   of the time spent on an item
// - one output register holds the current character; a stalled receiver
//   holds the program at its emit step until the register frees
// - reset returns the step counter to the load step and empties the output
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core #(
   parameter int WIDTH = sitoda_pkg::DEFAULT_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   // req_tdata: value (WIDTH bits), zero padded to whole bytes
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [((WIDTH+7)/8)*8-1:0]  req_tdata,
   // rsp_tdata: character (8 bits)
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,
   output logic                        rsp_tlast
);
   import sitoda_pkg::*;

   localparam int NDIG      = (WIDTH * 301) / 1000 + 1;
   localparam int BCD_W     = 4 * NDIG;
   localparam int BIT_CNT_W = $clog2(WIDTH + 1);
   localparam int DIG_CNT_W = $clog2(NDIG + 1);

   // step counter and datapath registers
   logic [PC_W-1:0]      pc_ff, pc_in;
   logic [WIDTH-1:0]     mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   ucode_type            uc;
   logic                 out_free;
   logic                 stall;
   logic                 take;
   logic [3:0]           lead;
   logic [WIDTH-1:0]     raw;
   logic [BCD_W-1:0]     adj_bcd;

   // control word fetch
   assign uc       = ucode_rom(pc_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign stall    = ((uc.act == ACT_SIGN) || (uc.act == ACT_DIGIT)) && !out_free;
   assign lead     = bcd_ff[BCD_W-1 -: 4];
   assign raw      = req_tdata[WIDTH-1:0];

   assign req_tready = (uc.act == ACT_LOAD);

   // jump condition
   always_comb begin
      unique case (uc.cond)
         COND_NEVER:       take = 1'b0;
         COND_ALWAYS:      take = 1'b1;
         COND_NO_INPUT:    take = !req_tvalid;
         COND_BITS_LEFT:   take = (bit_cnt_ff != BIT_CNT_W'(1));
         COND_NOT_NEG:     take = !neg_ff;
         COND_LEAD_ZERO:   take = (lead == 4'd0) && (dig_cnt_ff != DIG_CNT_W'(1));
         COND_DIGITS_LEFT: take = (dig_cnt_ff != DIG_CNT_W'(1));
         default:          take = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      if (stall) begin
         pc_in = pc_ff;
      end else if (take) begin
         pc_in = uc.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   // add 3 to every bcd digit of five or more
   always_comb begin
      for (int k = 0; k < NDIG; k++) begin
         if (bcd_ff[4*k +: 4] >= 4'd5) begin
            adj_bcd[4*k +: 4] = bcd_ff[4*k +: 4] + 4'd3;
         end else begin
            adj_bcd[4*k +: 4] = bcd_ff[4*k +: 4];
         end
      end
   end

   // datapath actions
   always_comb begin
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (uc.act)
         ACT_NONE: begin
         end
         ACT_LOAD: begin
            if (req_tvalid) begin
               neg_in     = raw[WIDTH-1];
               mag_in     = raw[WIDTH-1] ? (~raw + WIDTH'(1)) : raw;
               bcd_in     = '0;
               bit_cnt_in = BIT_CNT_W'(WIDTH);
               dig_cnt_in = DIG_CNT_W'(NDIG);
            end
         end
         ACT_DABBLE: begin
            bcd_in     = {adj_bcd[BCD_W-2:0], mag_ff[WIDTH-1]};
            mag_in     = {mag_ff[WIDTH-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 1'b1;
         end
         ACT_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = ASCII_MINUS;
               rsp_last_in  = 1'b0;
            end
         end
         ACT_SKIP: begin
            if (take) begin
               bcd_in     = {bcd_ff[BCD_W-5:0], 4'd0};
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end
         end
         ACT_DIGIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = ASCII_ZERO + {4'd0, lead};
               rsp_last_in  = (dig_cnt_ff == DIG_CNT_W'(1));
               bcd_in       = {bcd_ff[BCD_W-5:0], 4'd0};
               dig_cnt_in   = dig_cnt_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      bcd_ff      <= bcd_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### sv/sitoda_checker.sv
// ----------------------------------------------------------------------------
// sitoda_checker
// Port level checks of the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
module sitoda_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [7:0]                  rsp_tdata,
   input  logic                        rsp_tlast
);
   import sitoda_pkg::*;

   // a stalled character holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp item changed");

   // only a sign or a decimal digit goes out
   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == ASCII_MINUS) ||
                     ((rsp_tdata >= ASCII_ZERO) && (rsp_tdata <= ASCII_NINE)))
      else $error("rsp item is not a sign or digit");

   // a sign is never the final character
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata == ASCII_MINUS) |-> !rsp_tlast)
      else $error("sign marked as last character");

   // the converter is busy right after taking an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req item taken while conversion runs");

endmodule

bind signed_int_to_decimal_ascii_core sitoda_checker u_sitoda_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

### dv/tb_signed_int_to_decimal_ascii_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_core
// Drives signed integers into the converter and checks each ascii character
// of their decimal text, sign and last flag included, against a predicted
// text queue. A directed set covers zero, single digits, powers of ten and
// the range ends; random values follow, spread over every digit count.
// Both channels idle in random bursts, except over the final stretch.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii_core;
   import sitoda_pkg::*;

   localparam int VAL_W          = DEFAULT_WIDTH;
   localparam int DATA_W         = ((VAL_W + 7) / 8) * 8;
   localparam int RANDOM_ITEMS   = 200;
   localparam int QUIET_ITEMS    = 40;
   localparam int DRAIN_CYCLES   = 64;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int REPORT_LIMIT   = 10;

   // one character of decimal text
   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } text_char_type;

   // predicted decimal text and mismatch bookkeeping
   class decimal_text_board;
      text_char_type expected_text[$];
      int            mismatches;

      function new();
         mismatches = 0;
      endfunction

      function void note_error(string msg);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%s", msg);
         end
      endfunction

      // accepted value: append its characters, most significant first
      function void note_value(logic [VAL_W-1:0] value);
         logic [VAL_W-1:0] magnitude;
         logic [7:0]       digit_codes[$];
         text_char_type    entry;
         magnitude = value[VAL_W-1] ? (~value + 1'b1) : value;
         do begin
            digit_codes.push_front(ASCII_ZERO + 8'(magnitude % 10));
            magnitude = magnitude / 10;
         end while (magnitude != 0);
         if (value[VAL_W-1]) begin
            entry.code = ASCII_MINUS;
            entry.last = 1'b0;
            expected_text.push_back(entry);
         end
         foreach (digit_codes[k]) begin
            entry.code = digit_codes[k];
            entry.last = (k == digit_codes.size() - 1);
            expected_text.push_back(entry);
         end
      endfunction

      // accepted character: compare with the oldest prediction
      function void check_char(logic [7:0] code, logic last);
         text_char_type want;
         if (expected_text.size() == 0) begin
            note_error($sformatf("unexpected character %h last %b", code, last));
         end else begin
            want = expected_text.pop_front();
            if (want.code !== code || want.last !== last) begin
               note_error($sformatf("character mismatch: expected %h last %b, got %h last %b",
                                    want.code, want.last, code, last));
            end
         end
      endfunction

      function int pending();
         return expected_text.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata;   // value
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [7:0]        rsp_tdata;   // character
   logic              rsp_tlast;

   decimal_text_board board;
   bit                stalls_on;
   int                cycle_count;

   signed_int_to_decimal_ascii_core #(
      .WIDTH(VAL_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 2 ns clock
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_signed_int_to_decimal_ascii_core NOT OK");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_char(rsp_tdata, rsp_tlast);
      end
   end

   // receiver: ready with random stall bursts
   initial begin
      int run_len;
      int stall_len;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         run_len = $urandom_range(1, 40);
         repeat (run_len) @(posedge clock);
         if (stalls_on && $urandom_range(0, 1) == 1) begin
            rsp_tready <= 1'b0;
            stall_len = $urandom_range(1, 17);
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   // sender idle gap before the next item
   function automatic int pick_gap();
      if (stalls_on && $urandom_range(0, 3) == 0) begin
         return $urandom_range(1, 17);
      end
      return 0;
   endfunction

   // random value, spread evenly over digit counts, sometimes fully random
   function automatic logic [VAL_W-1:0] pick_value();
      longint           low_mag;
      longint           high_mag;
      longint           mag;
      int               ndig;
      bit               neg;
      logic [VAL_W-1:0] raw;
      if ($urandom_range(0, 4) == 0) begin
         return VAL_W'($urandom);
      end
      ndig = $urandom_range(1, 10);
      neg  = $urandom_range(0, 1);
      low_mag = 1;
      repeat (ndig - 1) low_mag = low_mag * 10;
      high_mag = low_mag * 10 - 1;
      if (ndig == 1) low_mag = 0;
      if (neg && high_mag > 64'h8000_0000) high_mag = 64'h8000_0000;
      if (!neg && high_mag > 64'h7fff_ffff) high_mag = 64'h7fff_ffff;
      mag = low_mag + longint'({32'd0, $urandom}) % (high_mag - low_mag + 1);
      raw = mag[VAL_W-1:0];
      return neg ? (~raw + 1'b1) : raw;
   endfunction

   // present one value and wait for it to be taken
   task automatic send_value(input logic [VAL_W-1:0] value, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'(value);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_value(value);
   endtask

   // main sequence
   initial begin
      logic [VAL_W-1:0] directed_values[22];
      board      = new();
      stalls_on  = 1'b1;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      directed_values = '{
         VAL_W'(0), VAL_W'(1), VAL_W'(-1), VAL_W'(9), VAL_W'(-9), VAL_W'(10),
         VAL_W'(-10), VAL_W'(99), VAL_W'(100), VAL_W'(-100), VAL_W'(42),
         32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, VAL_W'(1000000000),
         VAL_W'(999999999), VAL_W'(-999999999), VAL_W'(-1000000000),
         VAL_W'(1234567890), 32'h5555_5555, 32'haaaa_aaaa, VAL_W'(0)
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed values: zero, digit boundaries, range ends
      foreach (directed_values[i]) begin
         send_value(directed_values[i], pick_gap());
      end

      // random values, no idling over the last stretch
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - QUIET_ITEMS) stalls_on = 1'b0;
         send_value(pick_value(), pick_gap());
      end
      req_tvalid <= 1'b0;

      // drain
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.pending() != 0) begin
         board.note_error($sformatf("%0d characters never arrived", board.pending()));
      end
      if (board.mismatches == 0) begin
         $display("tb_signed_int_to_decimal_ascii_core OK");
      end else begin
         $display("tb_signed_int_to_decimal_ascii_core NOT OK");
      end
      $finish;
   end

endmodule
